[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define AST_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define AST_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/vfld_pkg.sv]
// ----------------------------------------------------------------------------
// Video frame layout detector package
// Shared constants and beat types for the layout detector.
// ----------------------------------------------------------------------------
`default_nettype none

package vfld_pkg;

  localparam int LINE_BITS        = 10;
  localparam int WAIT_BITS        = 7;
  localparam int FRAME_BITS       = 16;
  localparam int GARBAGE_BITS     = 8;
  localparam int VOTE_BITS_DEF    = 16;
  localparam int IN_TDATA_BITS    = 8;
  localparam int IN_TUSER_BITS    = 1;
  localparam int OUT_TDATA_BITS   = 16;

  localparam logic [LINE_BITS-1:0]    LINES_NTSC    = 10'd262;
  localparam logic [LINE_BITS-1:0]    LINES_PAL     = 10'd312;
  localparam logic [LINE_BITS-1:0]    VSYNC_LINES   = 10'd3;
  localparam logic [LINE_BITS-1:0]    DETECT_TOL    = 10'd20;
  localparam logic [LINE_BITS-1:0]    LINE_MAX      = 10'd1023;
  localparam logic [WAIT_BITS-1:0]    VSYNC_TIMEOUT = 7'd100;
  localparam logic [FRAME_BITS-1:0]   FRAMES_MAX    = 16'hFFFF;
  localparam logic [GARBAGE_BITS-1:0] GARBAGE_RESET = 8'd10;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_VSYNC = 1'b1;

  typedef struct packed {
    logic action;
    logic vsync_level;
  } item_t;

  // frame_done sits in the lowest bit.
  typedef struct packed {
    logic                 majority_pal;
    logic                 frame_is_pal;
    logic                 frame_counted;
    logic [LINE_BITS-1:0] frame_lines;
    logic                 frame_done;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);

endpackage

`default_nettype wire

[src/vfld_in_stage.sv]
// ----------------------------------------------------------------------------
// Layout detector input stage
// Registers one input beat and releases it when the update stage advances.
// ----------------------------------------------------------------------------
`default_nettype none

module vfld_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire vfld_pkg::item_t in_item,
  input  wire logic          advance,
  output logic               held_valid,
  output vfld_pkg::item_t    held_item
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

[src/vfld_classify.sv]
// ----------------------------------------------------------------------------
// Layout detector frame classifier
// Decides from a frame's line count whether the frame looks like PAL.
// ----------------------------------------------------------------------------
`default_nettype none

module vfld_classify (
  input  wire logic [vfld_pkg::LINE_BITS-1:0] lines,
  output logic                                is_pal
);

  logic [vfld_pkg::LINE_BITS-1:0] dn;
  logic [vfld_pkg::LINE_BITS-1:0] dp;
  logic [vfld_pkg::LINE_BITS-1:0] mn;
  logic                           nearer_pal;
  logic                           odd_between;

  always_comb begin
    dn = (lines >= vfld_pkg::LINES_NTSC) ? lines - vfld_pkg::LINES_NTSC
                                         : vfld_pkg::LINES_NTSC - lines;
    dp = (lines >= vfld_pkg::LINES_PAL) ? lines - vfld_pkg::LINES_PAL
                                        : vfld_pkg::LINES_PAL - lines;
    mn = (dn < dp) ? dn : dp;
    nearer_pal  = dp < dn;
    odd_between = (lines < vfld_pkg::LINES_PAL) && (lines > vfld_pkg::LINES_NTSC) && lines[0];
    if (mn <= vfld_pkg::DETECT_TOL) begin
      is_pal = nearer_pal;
    end else if (odd_between) begin
      is_pal = 1'b0;
    end else begin
      is_pal = nearer_pal;
    end
  end

endmodule

`default_nettype wire

[src/vfld_update.sv]
// ----------------------------------------------------------------------------
// Layout detector state update
// Vsync wait machine, frame bookkeeping, voting and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vfld_update #(
  parameter int VOTE_COUNT_BITS = vfld_pkg::VOTE_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_valid,
  input  wire logic [vfld_pkg::GARBAGE_BITS-1:0] cfg_data,
  input  wire logic            held_valid,
  input  wire vfld_pkg::item_t held_item,
  output logic                 advance,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output vfld_pkg::result_t    out_result
);

  typedef enum logic {
    WAIT_START,
    WAIT_END
  } phase_t;

  phase_t                              phase;
  phase_t                              phase_next;
  phase_t                              target;
  logic [vfld_pkg::WAIT_BITS-1:0]      wait_lines;
  logic [vfld_pkg::WAIT_BITS-1:0]      wait_lines_next;
  logic [vfld_pkg::WAIT_BITS-1:0]      wait_sum;
  logic [vfld_pkg::LINE_BITS-1:0]      line_count;
  logic [vfld_pkg::LINE_BITS-1:0]      line_count_next;
  logic [vfld_pkg::LINE_BITS-1:0]      line_inc;
  logic [vfld_pkg::LINE_BITS-1:0]      ideal_near;
  logic [vfld_pkg::FRAME_BITS-1:0]     frames_seen;
  logic [vfld_pkg::FRAME_BITS-1:0]     frames_seen_next;
  logic [VOTE_COUNT_BITS-1:0]          ntsc_votes;
  logic [VOTE_COUNT_BITS-1:0]          ntsc_votes_next;
  logic [VOTE_COUNT_BITS-1:0]          pal_votes;
  logic [VOTE_COUNT_BITS-1:0]          pal_votes_next;
  logic                                layout_pal;
  logic                                layout_pal_next;
  logic [vfld_pkg::GARBAGE_BITS-1:0]   garbage_frames;
  logic                                complete;
  logic                                counted;
  logic [vfld_pkg::LINE_BITS-1:0]      done_lines;
  logic                                done_pal;
  vfld_pkg::result_t                   result_next;

  assign advance = !out_valid || out_ready;

  vfld_classify u_classify (
    .lines  (done_lines),
    .is_pal (done_pal)
  );

  always_comb begin
    phase_next       = phase;
    wait_lines_next  = wait_lines;
    line_count_next  = line_count;
    complete         = 1'b0;
    target           = held_item.vsync_level ? WAIT_END : WAIT_START;
    wait_sum         = wait_lines;
    line_inc         = (line_count != vfld_pkg::LINE_MAX) ? line_count + 1'b1 : line_count;
    ideal_near       = layout_pal ? vfld_pkg::LINES_PAL - vfld_pkg::VSYNC_LINES
                                  : vfld_pkg::LINES_NTSC - vfld_pkg::VSYNC_LINES;

    if (held_item.action == vfld_pkg::ACT_VSYNC) begin
      if (target != phase) begin
        phase_next      = target;
        wait_lines_next = '0;
        complete        = (target == WAIT_START);
      end
    end else begin
      line_count_next = line_inc;
      case (phase)
        WAIT_START: begin
          if ((line_inc > ideal_near) || (frames_seen == '0)) begin
            wait_sum = wait_lines + 1'b1;
          end
          if (wait_sum > vfld_pkg::VSYNC_TIMEOUT) begin
            phase_next      = WAIT_END;
            wait_lines_next = '0;
          end else begin
            wait_lines_next = wait_sum;
          end
        end
        WAIT_END: begin
          wait_sum = wait_lines + 1'b1;
          if (wait_sum > vfld_pkg::VSYNC_TIMEOUT) begin
            phase_next      = WAIT_START;
            wait_lines_next = '0;
            complete        = 1'b1;
          end else begin
            wait_lines_next = wait_sum;
          end
        end
        default: begin
          phase_next = WAIT_START;
        end
      endcase
    end

    done_lines       = line_count_next;
    frames_seen_next = frames_seen;
    ntsc_votes_next  = ntsc_votes;
    pal_votes_next   = pal_votes;
    layout_pal_next  = layout_pal;
    counted          = 1'b0;

    if (complete) begin
      line_count_next = '0;
      if (frames_seen != vfld_pkg::FRAMES_MAX) begin
        frames_seen_next = frames_seen + 1'b1;
      end
      counted = frames_seen_next >
                {{(vfld_pkg::FRAME_BITS-vfld_pkg::GARBAGE_BITS){1'b0}}, garbage_frames};
      if (counted) begin
        layout_pal_next = done_pal;
        if (done_pal) begin
          if (!(&pal_votes)) begin
            pal_votes_next = pal_votes + 1'b1;
          end
        end else begin
          if (!(&ntsc_votes)) begin
            ntsc_votes_next = ntsc_votes + 1'b1;
          end
        end
      end
    end

    result_next.frame_done    = complete;
    result_next.frame_lines   = complete ? done_lines : '0;
    result_next.frame_counted = counted;
    result_next.frame_is_pal  = layout_pal_next;
    result_next.majority_pal  = pal_votes_next > ntsc_votes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= WAIT_START;
      wait_lines     <= '0;
      line_count     <= '0;
      frames_seen    <= '0;
      ntsc_votes     <= '0;
      pal_votes      <= '0;
      layout_pal     <= 1'b0;
      garbage_frames <= vfld_pkg::GARBAGE_RESET;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        garbage_frames <= cfg_data;
      end
      if (advance) begin
        out_valid <= held_valid;
      end
      if (held_valid && advance) begin
        phase       <= phase_next;
        wait_lines  <= wait_lines_next;
        line_count  <= line_count_next;
        frames_seen <= frames_seen_next;
        ntsc_votes  <= ntsc_votes_next;
        pal_votes   <= pal_votes_next;
        layout_pal  <= layout_pal_next;
      end
    end
    if (held_valid && advance) begin
      out_result <= result_next;
    end
  end

endmodule

`default_nettype wire

[src/video_frame_layout_detector_core.sv]
// ----------------------------------------------------------------------------
// Video frame layout detector core
// Classifies frames as NTSC or PAL from scanline ticks and vsync writes.
// ----------------------------------------------------------------------------
// Each slave beat is either a scanline tick or a vsync level write, chosen by
// s_axis_tuser. Every beat produces exactly one master beat, carrying whether
// a frame ended, its line count, whether it voted and the current layout.
// The garbage frame count is written through the cfg channel, which is always
// ready; it should only be written while no beats are in flight.
// A beat passes an input register and then the update logic into the result
// register. One beat is accepted in every cycle while the master side takes
// results. When the receiver stalls, the result register holds and the input
// register takes one further beat; s_axis_tready then falls until the stall
// clears. Reset clears all counters, selects NTSC, sets the garbage frame
// count to ten and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module video_frame_layout_detector_core #(
  parameter int VOTE_COUNT_BITS = vfld_pkg::VOTE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  // [0] vsync_level, [7:1] zero
  input  wire logic [vfld_pkg::IN_TDATA_BITS-1:0] s_axis_tdata,
  // [0] action
  input  wire logic [vfld_pkg::IN_TUSER_BITS-1:0] s_axis_tuser,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  // [0] frame_done, [10:1] frame_lines, [11] frame_counted,
  // [12] frame_is_pal, [13] majority_pal, [15:14] zero
  output logic [vfld_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [vfld_pkg::GARBAGE_BITS-1:0] cfg_data
);

  vfld_pkg::item_t   in_item;
  vfld_pkg::item_t   held_item;
  vfld_pkg::result_t out_result;
  logic              held_valid;
  logic              advance;

  assign in_item.action      = s_axis_tuser[0];
  assign in_item.vsync_level = s_axis_tdata[0];
  assign cfg_ready           = 1'b1;
  assign m_axis_tdata        = {{(vfld_pkg::OUT_TDATA_BITS-vfld_pkg::RESULT_BITS){1'b0}},
                                out_result};

  vfld_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  vfld_update #(
    .VOTE_COUNT_BITS (VOTE_COUNT_BITS)
  ) u_update (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .held_valid (held_valid),
    .held_item  (held_item),
    .advance    (advance),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (out_result)
  );

endmodule

`default_nettype wire

[src/vfld_checker.sv]
// ----------------------------------------------------------------------------
// Layout detector port checker
// Port-level assertions, bound to the detector core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vfld_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  `AST_CLK_ALWAYS(a_reset_empties, rst |=> !m_axis_tvalid, "output valid after reset")
  `AST_CLK(a_stall_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")
  `AST_CLK(a_lines_only_done, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[10:1] == 10'd0, "line count without frame end")
  `AST_CLK(a_counted_done, m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[0], "vote without frame end")
  `AST_CLK(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")

endmodule

bind video_frame_layout_detector_core vfld_checker u_vfld_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
